>>> src/mi3_pkg.sv
// ----------------------------------------------------------------------------
// mi3_pkg: shared types and constants of the 3x3 matrix inverse
// Default widths, state machine encoding and the controller command and status structs.
// ----------------------------------------------------------------------------
package mi3_pkg;

  localparam int DataWidthDef = 24;
  localparam int FracBitsDef  = 16;
  localparam int NumElem      = 9;
  localparam int IdxW         = 4;

  typedef enum logic [2:0] {
    ST_LOAD,
    ST_COF,
    ST_DET,
    ST_DIV,
    ST_EMIT
  } mi3_state_t;

  typedef struct packed {
    logic            store_en;
    logic            cof_start;
    logic            det_start;
    logic            div_start;
    logic [IdxW-1:0] res_idx;
  } mi3_cmd_t;

  typedef struct packed {
    logic cof_done;
    logic det_done;
    logic div_done;
    logic singular;
  } mi3_stat_t;

endpackage

>>> src/mi3_stream_if.sv
// ----------------------------------------------------------------------------
// mi3_stream_if: valid/ready channel
// Carries one beat of payload from a source to a sink.
// ----------------------------------------------------------------------------
interface mi3_stream_if #(
  parameter int PayloadWidth = 24
);
  logic                    valid;
  logic                    ready;
  logic [PayloadWidth-1:0] payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

>>> src/mi3_ctrl.sv
// ----------------------------------------------------------------------------
// mi3_ctrl: sequencing controller
// Counts loaded elements and steps through cofactors, determinant and the
// nine quotients (skipped for a singular matrix), presenting each result until it is taken.
// ----------------------------------------------------------------------------
module mi3_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  output logic               out_valid,
  input  logic               out_ready,
  output logic               out_last,
  output mi3_pkg::mi3_cmd_t  cmd,
  input  mi3_pkg::mi3_stat_t stat
);
  import mi3_pkg::*;

  mi3_state_t      state_r, state_nxt;
  logic [IdxW-1:0] cnt_r, cnt_nxt;
  logic            in_fire, out_fire;

  assign in_fire  = in_valid && in_ready;
  assign out_fire = out_valid && out_ready;

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    case (state_r)
      ST_LOAD: begin
        if (in_fire) begin
          if (cnt_r == IdxW'(NumElem - 1)) begin
            cnt_nxt   = '0;
            state_nxt = ST_COF;
          end else begin
            cnt_nxt = cnt_r + 1'b1;
          end
        end
      end
      ST_COF: if (stat.cof_done) state_nxt = ST_DET;
      ST_DET: begin
        if (stat.det_done) state_nxt = stat.singular ? ST_EMIT : ST_DIV;
      end
      ST_DIV: if (stat.div_done) state_nxt = ST_EMIT;
      ST_EMIT: begin
        if (out_fire) begin
          if (cnt_r == IdxW'(NumElem - 1)) begin
            cnt_nxt   = '0;
            state_nxt = ST_LOAD;
          end else begin
            cnt_nxt   = cnt_r + 1'b1;
            state_nxt = stat.singular ? ST_EMIT : ST_DIV;
          end
        end
      end
      default: state_nxt = ST_LOAD;
    endcase
  end

  always_comb begin
    in_ready      = (state_r == ST_LOAD);
    out_valid     = (state_r == ST_EMIT);
    out_last      = (state_r == ST_EMIT) && (cnt_r == IdxW'(NumElem - 1));
    cmd.store_en  = in_fire;
    // The divider loads the operands of the result that comes next.
    cmd.res_idx   = cnt_nxt;
    cmd.cof_start = (state_r == ST_LOAD) && in_fire && (cnt_r == IdxW'(NumElem - 1));
    cmd.det_start = (state_r == ST_COF) && stat.cof_done;
    cmd.div_start = ((state_r == ST_DET) && stat.det_done && !stat.singular) ||
                    ((state_r == ST_EMIT) && out_fire && !stat.singular &&
                     (cnt_r != IdxW'(NumElem - 1)));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_LOAD;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

endmodule

>>> src/mi3_datapath.sv
// ----------------------------------------------------------------------------
// mi3_datapath: element store, shared multiplier and restoring divider
// Cofactors take eighteen products on one multiplier, the determinant six
// more; each quotient is formed one bit per cycle.
// ----------------------------------------------------------------------------
module mi3_datapath #(
  parameter int DataWidth = mi3_pkg::DataWidthDef,
  parameter int FracBits  = mi3_pkg::FracBitsDef
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  mi3_pkg::mi3_cmd_t     cmd,
  output mi3_pkg::mi3_stat_t    stat,
  input  logic [DataWidth-1:0]  in_data,
  output logic [DataWidth-1:0]  res_value
);
  import mi3_pkg::*;

  localparam int PW  = 2 * DataWidth;       // product width
  localparam int CW  = PW + 1;              // cofactor width
  localparam int DW  = CW + DataWidth + 2;  // determinant width
  localparam int NW  = CW + 2 * FracBits;   // shifted numerator width
  localparam int QW  = NW;                  // quotient bits
  localparam int QCW = $clog2(QW + 1);

  logic signed [DataWidth-1:0] store_r [NumElem];
  logic signed [CW-1:0]        cof_r [NumElem];
  logic signed [DW-1:0]        det_r;
  logic [IdxW-1:0]             wptr_r;
  logic signed [PW-1:0]        prod_r;
  logic [4:0]                  step_r;
  logic                        cof_busy_r, det_busy_r, prod_vld_r;
  logic                        cof_done_r, det_done_r;

  // Flat element index from a row and a column.
  function automatic logic [IdxW-1:0] ix(input logic [1:0] r, input logic [1:0] c);
    return IdxW'(r) * IdxW'(3) + IdxW'(c);
  endfunction

  function automatic logic [1:0] inc3(input logic [1:0] v, input logic [1:0] k);
    logic [2:0] s;
    s = 3'(v) + 3'(k);
    return (s >= 3'd3) ? 2'(s - 3'd3) : s[1:0];
  endfunction

  logic [3:0] cof_k;
  logic       term_b;
  logic [1:0] ci, cj;
  logic signed [DataWidth-1:0] op_a;
  logic signed [DataWidth:0]   op_b;
  logic signed [PW:0]          mul_p;
  logic signed [CW-1:0]        det_cof;

  assign cof_k  = step_r[4:1];
  assign term_b = step_r[0];

  always_comb begin
    ci = 2'd0;
    cj = 2'd0;
    case (cof_k)
      4'd0: begin ci = 2'd0; cj = 2'd0; end
      4'd1: begin ci = 2'd0; cj = 2'd1; end
      4'd2: begin ci = 2'd0; cj = 2'd2; end
      4'd3: begin ci = 2'd1; cj = 2'd0; end
      4'd4: begin ci = 2'd1; cj = 2'd1; end
      4'd5: begin ci = 2'd1; cj = 2'd2; end
      4'd6: begin ci = 2'd2; cj = 2'd0; end
      4'd7: begin ci = 2'd2; cj = 2'd1; end
      4'd8: begin ci = 2'd2; cj = 2'd2; end
      default: begin ci = 2'd0; cj = 2'd0; end
    endcase
    det_cof = cof_r[ix(2'd0, step_r[2:1])];
    if (det_busy_r) begin
      // Each determinant term takes two passes: the low cofactor half is
      // unsigned, the high half carries the sign.
      op_a = store_r[ix(2'd0, step_r[2:1])];
      op_b = step_r[0] ? det_cof[CW-1:DataWidth] : {1'b0, det_cof[DataWidth-1:0]};
    end else if (!term_b) begin
      op_a = store_r[ix(inc3(ci, 2'd1), inc3(cj, 2'd1))];
      op_b = (DataWidth + 1)'(store_r[ix(inc3(ci, 2'd2), inc3(cj, 2'd2))]);
    end else begin
      op_a = store_r[ix(inc3(ci, 2'd2), inc3(cj, 2'd1))];
      op_b = (DataWidth + 1)'(store_r[ix(inc3(ci, 2'd1), inc3(cj, 2'd2))]);
    end
    mul_p = op_a * op_b;
  end

  logic signed [DW-1:0] det_term;
  assign det_term = step_r[0] ? (DW'(mul_p) <<< DataWidth) : DW'(mul_p);

  logic [4:0]           pidx_r;
  logic signed [CW-1:0] cof_acc_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r     <= '0;
      cof_busy_r <= 1'b0;
      det_busy_r <= 1'b0;
      prod_vld_r <= 1'b0;
      cof_done_r <= 1'b0;
      det_done_r <= 1'b0;
      step_r     <= '0;
      pidx_r     <= '0;
    end else begin
      cof_done_r <= 1'b0;
      det_done_r <= 1'b0;
      if (cmd.store_en) begin
        store_r[wptr_r] <= in_data;
        wptr_r <= (wptr_r == IdxW'(NumElem - 1)) ? '0 : wptr_r + 1'b1;
      end
      if (cmd.cof_start) begin
        cof_busy_r <= 1'b1;
        step_r     <= '0;
        prod_vld_r <= 1'b0;
      end else if (cof_busy_r) begin
        prod_r     <= mul_p[PW-1:0];
        pidx_r     <= step_r;
        prod_vld_r <= 1'b1;
        if (step_r != 5'd17) step_r <= step_r + 1'b1;
        if (prod_vld_r) begin
          if (!pidx_r[0]) begin
            cof_acc_r <= CW'(prod_r);
          end else begin
            cof_r[pidx_r[4:1]] <= cof_acc_r - CW'(prod_r);
            if (pidx_r == 5'd17) begin
              cof_busy_r <= 1'b0;
              prod_vld_r <= 1'b0;
              cof_done_r <= 1'b1;
            end
          end
        end
      end
      if (cmd.det_start) begin
        det_busy_r <= 1'b1;
        step_r     <= '0;
        det_r      <= '0;
      end else if (det_busy_r) begin
        det_r  <= det_r + det_term;
        step_r <= step_r + 1'b1;
        if (step_r == 5'd5) begin
          det_busy_r <= 1'b0;
          det_done_r <= 1'b1;
        end
      end
    end
  end

  // Restoring division of |cofactor| << 2F by |det|, one quotient bit a cycle.
  logic [NW-1:0]  num_r;
  logic [DW-1:0]  den_r;
  logic [DW:0]    rem_r;
  logic [QW-1:0]  quo_r;
  logic [QCW-1:0] bcnt_r;
  logic           neg_r, div_busy_r, div_done_r;
  logic [DataWidth-1:0] res_r;

  logic [1:0]           ri, rj;
  logic signed [CW-1:0] cof_sel;
  logic [DW:0]          rem_sh, rem_sub;
  logic [CW-1:0]        cof_mag;
  logic [DW-1:0]        det_mag;
  logic                 det_neg;

  always_comb begin
    case (cmd.res_idx)
      4'd0: begin ri = 2'd0; rj = 2'd0; end
      4'd1: begin ri = 2'd0; rj = 2'd1; end
      4'd2: begin ri = 2'd0; rj = 2'd2; end
      4'd3: begin ri = 2'd1; rj = 2'd0; end
      4'd4: begin ri = 2'd1; rj = 2'd1; end
      4'd5: begin ri = 2'd1; rj = 2'd2; end
      4'd6: begin ri = 2'd2; rj = 2'd0; end
      4'd7: begin ri = 2'd2; rj = 2'd1; end
      default: begin ri = 2'd2; rj = 2'd2; end
    endcase
    cof_sel = cof_r[ix(rj, ri)];
    cof_mag = cof_sel[CW-1] ? CW'(-cof_sel) : CW'(cof_sel);
    det_neg = det_r[DW-1];
    det_mag = det_neg ? DW'(-det_r) : DW'(det_r);
    rem_sh  = {rem_r[DW-1:0], num_r[NW-1]};
    rem_sub = rem_sh - {1'b0, den_r};
  end

  localparam logic [QW-1:0] MaxPos = QW'((64'd1 << (DataWidth - 1)) - 64'd1);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      div_busy_r <= 1'b0;
      div_done_r <= 1'b0;
    end else begin
      div_done_r <= 1'b0;
      if (cmd.div_start) begin
        div_busy_r <= 1'b1;
        num_r      <= {cof_mag, {(2 * FracBits){1'b0}}};
        den_r      <= det_mag;
        rem_r      <= '0;
        quo_r      <= '0;
        bcnt_r     <= QCW'(QW);
        neg_r      <= cof_sel[CW-1] ^ det_neg;
      end else if (div_busy_r) begin
        if (bcnt_r != '0) begin
          num_r  <= num_r << 1;
          bcnt_r <= bcnt_r - 1'b1;
          if (!rem_sub[DW]) begin
            rem_r <= rem_sub;
            quo_r <= {quo_r[QW-2:0], 1'b1};
          end else begin
            rem_r <= rem_sh;
            quo_r <= {quo_r[QW-2:0], 1'b0};
          end
        end else begin
          div_busy_r <= 1'b0;
          div_done_r <= 1'b1;
          if (neg_r) begin
            res_r <= (quo_r > MaxPos) ? {1'b1, {(DataWidth-1){1'b0}}}
                                      : DataWidth'(-quo_r);
          end else begin
            res_r <= (quo_r > MaxPos) ? {1'b0, {(DataWidth-1){1'b1}}}
                                      : DataWidth'(quo_r);
          end
        end
      end
    end
  end

  assign stat.cof_done = cof_done_r;
  assign stat.det_done = det_done_r;
  assign stat.div_done = div_done_r;
  assign stat.singular = (det_r == '0);
  assign res_value     = stat.singular ? '0 : res_r;

endmodule

>>> src/matrix3x3_inverse.sv
// Order: after the ninth element beat the cofactors are formed, then the
// determinant, then each quotient in turn by the bit-serial divider, the next
// only after the previous result is taken. A singular matrix skips the divider
// and emits one result per cycle while out_ready is high. Loading takes one
// element beat per cycle; a new matrix is accepted once all nine results are taken.
// Reset: synchronous active-low rst_n returns to loading with zero count.
// ----------------------------------------------------------------------------
// matrix3x3_inverse: 3x3 fixed-point matrix inverse by the adjugate
// Loads nine elements, then emits nine saturated inverse elements (zeros if singular).
// ----------------------------------------------------------------------------
module matrix3x3_inverse #(
  parameter int DATA_WIDTH = mi3_pkg::DataWidthDef,
  parameter int FRAC_BITS  = mi3_pkg::FracBitsDef
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [DATA_WIDTH-1:0] in_element_value,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [DATA_WIDTH-1:0] out_inverse_value,
  output logic                  out_singular,
  output logic                  out_last
);
  import mi3_pkg::*;

  mi3_cmd_t  cmd;
  mi3_stat_t stat;

  mi3_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_last  (out_last),
    .cmd       (cmd),
    .stat      (stat)
  );

  mi3_datapath #(
    .DataWidth (DATA_WIDTH),
    .FracBits  (FRAC_BITS)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .stat      (stat),
    .in_data   (in_element_value),
    .res_value (out_inverse_value)
  );

  assign out_singular = stat.singular;

endmodule

>>> src/mi3_checker.sv
// ----------------------------------------------------------------------------
// mi3_checker: port-level checks of the matrix inverse
// Watches the handshake and the framing of result beats.
// ----------------------------------------------------------------------------
module mi3_checker (
  input logic clk,
  input logic rst_n,
  input logic in_valid,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready,
  input logic out_singular,
  input logic out_last
);
  // Loading and emitting never overlap.
  a_excl: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_ready && out_valid)) else $error("input and output both active");

  // A pending result stays until taken.
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid) else $error("result dropped");

  // The singular flag holds through a matrix.
  a_sing: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && !out_last |=> $stable(out_singular))
    else $error("singular flag changed");

  // After the last beat the block returns to loading.
  a_back: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && out_last |=> in_ready) else $error("no reload");
endmodule

bind matrix3x3_inverse mi3_checker u_mi3_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .in_valid     (in_valid),
  .in_ready     (in_ready),
  .out_valid    (out_valid),
  .out_ready    (out_ready),
  .out_singular (out_singular),
  .out_last     (out_last)
);

>>> tb/sv/tb.sv
// ----------------------------------------------------------------------------
// tb: self-checking testbench of matrix3x3_inverse
// Streams 3x3 Q8.16 matrices in, predicts the nine saturated inverse elements
// of each by the adjugate with exact wide arithmetic, and checks every result
// beat in order under random input gaps and output stalls.
// ----------------------------------------------------------------------------
module tb;
  import mi3_pkg::*;

  localparam int W     = DataWidthDef;
  localparam int F     = FracBitsDef;
  localparam int MAXV  = (1 << (W - 1)) - 1;
  localparam int MINV  = -(1 << (W - 1));

  typedef logic signed [127:0] wide_t;
  typedef logic signed [W-1:0] elem_t;

  typedef struct packed {
    logic [W-1:0] value;
    logic         singular;
    logic         last;
  } inv_beat_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  mi3_stream_if #(.PayloadWidth(W))     elem_if ();
  mi3_stream_if #(.PayloadWidth(W + 2)) inv_if ();

  matrix3x3_inverse DUT (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (elem_if.valid),
    .in_ready          (elem_if.ready),
    .in_element_value  (elem_if.payload),
    .out_valid         (inv_if.valid),
    .out_ready         (inv_if.ready),
    .out_inverse_value (inv_if.payload[W+1:2]),
    .out_singular      (inv_if.payload[1]),
    .out_last          (inv_if.payload[0])
  );

  always #10 clk = ~clk;

  inv_beat_t expected_inv[$];
  elem_t     matrix_buf[9];
  int        load_cnt = 0;
  int        mismatches = 0;

  // Exact adjugate inverse of the captured matrix, saturated to W bits.
  function automatic wide_t elem_at(int r, int c);
    return wide_t'(matrix_buf[(r * 3 + c) % 9]);
  endfunction

  function automatic wide_t cofactor_of(int i, int j);
    int r0, r1, c0, c1;
    r0 = (i + 1) % 3;
    r1 = (i + 2) % 3;
    c0 = (j + 1) % 3;
    c1 = (j + 2) % 3;
    return elem_at(r0, c0) * elem_at(r1, c1) - elem_at(r1, c0) * elem_at(r0, c1);
  endfunction

  task automatic predict_inverse();
    wide_t cof[3][3];
    wide_t det, quo;
    inv_beat_t b;
    det = 0;
    for (int i = 0; i < 3; i++)
      for (int j = 0; j < 3; j++) cof[i][j] = cofactor_of(i, j);
    for (int j = 0; j < 3; j++) det = det + elem_at(0, j) * cof[0][j];
    for (int k = 0; k < 9; k++) begin
      b.singular = (det == 0);
      b.last = (k == 8);
      if (det == 0) begin
        b.value = '0;
      end else begin
        quo = (cof[k % 3][k / 3] <<< (2 * F)) / det;
        if (quo > MAXV) quo = MAXV;
        if (quo < MINV) quo = MINV;
        b.value = quo[W-1:0];
      end
      expected_inv.insert(expected_inv.size(), b);
    end
  endtask

  // Element beats feed the predictor, result beats are checked in order.
  always @(posedge clk) begin
    inv_beat_t got, exp_b;
    if (rst_n && elem_if.valid && elem_if.ready) begin
      matrix_buf[load_cnt] = elem_if.payload;
      load_cnt = load_cnt + 1;
      if (load_cnt == 9) begin
        load_cnt = 0;
        predict_inverse();
      end
    end
    if (rst_n && inv_if.valid && inv_if.ready) begin
      got = inv_if.payload;
      if (expected_inv.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result beat %h", got);
      end else begin
        exp_b = expected_inv.pop_front();
        if (got !== exp_b) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: expected value %h sing %b last %b, got %h %b %b",
                     exp_b.value, exp_b.singular, exp_b.last,
                     got.value, got.singular, got.last);
        end
      end
    end
  end

  // Receiver: stall pattern alternates between busy stretches and open ones.
  int stall_phase = 0;
  always @(negedge clk) begin
    stall_phase = (stall_phase + 1) % 400;
    if (stall_phase < 150) inv_if.ready <= 1'b1;
    else inv_if.ready <= ($urandom_range(0, 3) != 0);
  end

  initial inv_if.ready = 1'b0;

  bit last_accepted = 1'b0;
  always @(posedge clk) last_accepted <= elem_if.valid && elem_if.ready;

  task automatic send_element(input elem_t v);
    int gap;
    gap = ($urandom_range(0, 4) == 0) ? $urandom_range(1, 6) : 0;
    if (gap > 0) begin
      elem_if.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    elem_if.valid <= 1'b1;
    elem_if.payload <= v;
    do @(negedge clk); while (!last_accepted);
  endtask

  task automatic send_matrix(input elem_t m[9]);
    for (int k = 0; k < 9; k++) send_element(m[k]);
  endtask

  task automatic test_identity();
    elem_t m[9];
    m = '{24'sh020000, 0, 0, 0, 24'sh020000, 0, 0, 0, 24'sh020000};
    send_matrix(m);
  endtask

  task automatic test_singular_extremes();
    elem_t m[9];
    m = '{elem_t'(MAXV), elem_t'(MINV), elem_t'(MAXV),
          elem_t'(MAXV), elem_t'(MINV), elem_t'(MAXV), 1, 2, 3};
    send_matrix(m);
  endtask

  task automatic test_saturation();
    elem_t m[9];
    // A determinant of minus one LSB cubed pushes every nonzero quotient to a bound.
    m = '{1, 0, 0, 0, -1, 0, 0, 0, 1};
    send_matrix(m);
  endtask

  function automatic elem_t rand_elem(int span);
    return elem_t'($urandom_range(0, 2 * span) - span);
  endfunction

  task automatic test_random(input int n_matrices);
    elem_t m[9];
    int mode;
    for (int n = 0; n < n_matrices; n++) begin
      mode = $urandom_range(0, 4);
      for (int k = 0; k < 9; k++) begin
        case (mode)
          0: m[k] = elem_t'($urandom());
          1: m[k] = rand_elem(1 << 17);
          2: m[k] = (k % 4 == 0) ? rand_elem(MAXV) : rand_elem(1 << 12);
          3: m[k] = rand_elem(4);
          default: m[k] = (k >= 6) ? m[k - 6] : elem_t'($urandom());
        endcase
      end
      send_matrix(m);
    end
  endtask

  initial begin
    elem_if.valid = 1'b0;
    elem_if.payload = '0;
    repeat (3) @(negedge clk);
    rst_n = 1'b1;
    test_identity();
    test_singular_extremes();
    test_saturation();
    test_random(36);
    elem_if.valid <= 1'b0;
    while (expected_inv.size() != 0) @(negedge clk);
    repeat (100) @(negedge clk);
    if (mismatches == 0 && expected_inv.size() == 0) $display("DONE: 0 errors");
    else $display("DONE: errors detected");
    $finish;
  end

  initial begin
    #20000000;
    $display("DONE: errors detected");
    $finish;
  end

endmodule
